>>> rtl/bbn_pkg.sv
// Package for the bounding-box NMS block: payload types, constants and a helper.
package bbn_pkg;

  localparam int MaxBoxesDefault  = 64;
  localparam int CoordBitsDefault = 12;
  localparam int ScoreBits        = 16;
  localparam int ClassBits        = 2;
  localparam logic [15:0] ThrReset = 16'd32768;
  localparam logic [1:0]  RegIouThreshold = 2'd0;

  typedef struct packed {
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [11:0] box_right;
    logic [11:0] box_bottom;
    logic [15:0] score;
    logic [1:0]  class_label;
    logic        last_box;
  } box_in_t;

  typedef struct packed {
    logic [11:0] kept_left;
    logic [11:0] kept_top;
    logic [11:0] kept_right;
    logic [11:0] kept_bottom;
    logic [15:0] kept_score;
    logic [1:0]  kept_class;
    logic        overflow;
    logic        last_kept;
  } box_out_t;

  // Inclusive extent of lo..hi, zero when hi < lo.
  function automatic logic [12:0] span(input logic [11:0] lo, input logic [11:0] hi);
    span = (hi >= lo) ? ({1'b0, hi} - {1'b0, lo} + 13'd1) : 13'd0;
  endfunction

endpackage

>>> rtl/bbn_cell.sv
// One cell of the chain: holds one box and its keep flag, passes the probe box on.
module bbn_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bbn_pkg::box_in_t load_box,
  input  logic             clear,
  input  logic             probe_valid_in,
  input  bbn_pkg::box_in_t probe_in,
  output logic             probe_valid_out,
  output bbn_pkg::box_in_t probe_out,
  input  logic [15:0]      thr,
  output bbn_pkg::box_in_t box,
  output logic             occupied,
  output logic             keep
);

  import bbn_pkg::*;

  // Stage 1 registers: intersection and union areas of probe versus this cell.
  logic        s1_valid;
  logic        s1_higher;
  logic [25:0] s1_inter;
  logic [25:0] s1_uni;
  // Stage 2 registers: the two products.
  logic        s2_valid;
  logic        s2_higher;
  logic [41:0] s2_lhs;
  logic [41:0] s2_rhs;

  logic [11:0] xa, ya, xb, yb;
  logic [25:0] inter, area_a, area_b;
  logic [26:0] uni_sum;

  always_comb begin
    xa = (box.box_left > probe_in.box_left) ? box.box_left : probe_in.box_left;
    ya = (box.box_top > probe_in.box_top) ? box.box_top : probe_in.box_top;
    xb = (box.box_right < probe_in.box_right) ? box.box_right : probe_in.box_right;
    yb = (box.box_bottom < probe_in.box_bottom) ? box.box_bottom : probe_in.box_bottom;
    inter  = span(xa, xb) * span(ya, yb);
    area_a = span(box.box_left, box.box_right) * span(box.box_top, box.box_bottom);
    area_b = span(probe_in.box_left, probe_in.box_right)
           * span(probe_in.box_top, probe_in.box_bottom);
    uni_sum = {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter};
  end

  always_ff @(posedge clk) begin
    if (load) box <= load_box;
    probe_out <= probe_in;
    s1_inter  <= inter;
    s1_uni    <= uni_sum[25:0];
    s1_higher <= probe_in.score > box.score;
    s2_lhs    <= {s1_inter, 16'd0};
    s2_rhs    <= {16'd0, s1_uni} * {26'd0, thr};
    s2_higher <= s1_higher;
    if (rst) begin
      occupied        <= 1'b0;
      keep            <= 1'b0;
      probe_valid_out <= 1'b0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
    end else begin
      probe_valid_out <= probe_valid_in;
      s1_valid        <= probe_valid_in && occupied;
      s2_valid        <= s1_valid;
      if (clear) begin
        occupied <= 1'b0;
      end else if (load) begin
        occupied <= 1'b1;
        keep     <= 1'b1;
      end else if (s2_valid && s2_higher && (s2_lhs > s2_rhs)) begin
        keep <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/bounding_box_nms.sv
// Top level: box loader, chain of compare cells and result emitter.
// Boxes are accepted only while the block is loading. The closing box starts a pass in
// which every stored box travels down the chain of cells, one cell per cycle;
// results then leave one per cycle as the consumer allows. Reset clears the
// count, the overflow flag and all cell flags and sets the threshold to 0.5;
// box contents are not cleared.
module bounding_box_nms #(
  parameter int MAX_BOXES = bbn_pkg::MaxBoxesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bbn_pkg::box_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bbn_pkg::box_out_t    out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import bbn_pkg::*;

  localparam int IdxBits = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CntBits = $clog2(MAX_BOXES + 1);
  localparam int PassLen = 2 * MAX_BOXES + 4;
  localparam int TmrBits = $clog2(PassLen + 1);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StPass = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]         state;
  logic [15:0]        thr;
  logic [CntBits-1:0] count;
  logic               ovf;
  logic [TmrBits-1:0] tmr;
  logic [IdxBits-1:0] emit_idx;
  logic [CntBits-1:0] feed_idx;

  logic               pv   [MAX_BOXES+1];
  box_in_t            pb   [MAX_BOXES+1];
  box_in_t            boxes[MAX_BOXES];
  logic [MAX_BOXES-1:0] occ, kp;
  logic               clear_all;
  logic               in_acc, out_acc;

  assign pready   = 1'b1;
  assign prdata   = {16'd0, thr};
  assign in_stall = (state != StLoad);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // Feed stored boxes into the head of the chain one per cycle.
  assign pv[0] = (state == StPass) && (feed_idx < count);
  assign pb[0] = boxes[feed_idx[IdxBits-1:0]];

  generate
    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
      bbn_cell u_cell (
        .clk(clk), .rst(rst),
        .load(in_acc && (count == CntBits'(g))),
        .load_box(in_data),
        .clear(clear_all),
        .probe_valid_in(pv[g]), .probe_in(pb[g]),
        .probe_valid_out(pv[g+1]), .probe_out(pb[g+1]),
        .thr(thr), .box(boxes[g]), .occupied(occ[g]), .keep(kp[g])
      );
    end
  endgenerate

  logic [MAX_BOXES-1:0] live, above;
  logic                 more;
  always_comb begin
    live  = occ & kp;
    above = '0;
    for (int k = 0; k < MAX_BOXES; k++) above[k] = (k > int'(emit_idx));
    more  = |(live & above);
  end

  logic [IdxBits-1:0] next_live;
  always_comb begin
    next_live = emit_idx;
    for (int k = MAX_BOXES - 1; k >= 0; k--) begin
      if (live[k] && above[k]) next_live = IdxBits'(k);
    end
  end

  assign clear_all = (state == StEmit) && out_acc && !more;
  assign out_valid = (state == StEmit);
  always_comb begin
    out_data.kept_left   = boxes[emit_idx].box_left;
    out_data.kept_top    = boxes[emit_idx].box_top;
    out_data.kept_right  = boxes[emit_idx].box_right;
    out_data.kept_bottom = boxes[emit_idx].box_bottom;
    out_data.kept_score  = boxes[emit_idx].score;
    out_data.kept_class  = boxes[emit_idx].class_label;
    out_data.overflow    = ovf;
    out_data.last_kept   = !more;
  end

  logic [IdxBits-1:0] first_live;
  always_comb begin
    first_live = '0;
    for (int k = MAX_BOXES - 1; k >= 0; k--) begin
      if (live[k]) first_live = IdxBits'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= StLoad;
      thr      <= ThrReset;
      count    <= '0;
      ovf      <= 1'b0;
      tmr      <= '0;
      feed_idx <= '0;
      emit_idx <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == RegIouThreshold[0]))
        thr <= pwdata[15:0];
      unique case (state)
        StLoad: begin
          if (in_acc) begin
            if (count < CntBits'(MAX_BOXES)) count <= count + 1'b1;
            else ovf <= 1'b1;
            if (in_data.last_box) begin
              state    <= StPass;
              tmr      <= '0;
              feed_idx <= '0;
            end
          end
        end
        StPass: begin
          if (feed_idx < count) feed_idx <= feed_idx + 1'b1;
          tmr <= tmr + 1'b1;
          if (tmr == TmrBits'(PassLen)) begin
            state    <= StEmit;
            emit_idx <= first_live;
          end
        end
        StEmit: begin
          if (out_acc) begin
            if (more) begin
              emit_idx <= next_live;
            end else begin
              state <= StLoad;
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: state <= StLoad;
      endcase
    end
  end

endmodule

>>> bench/bounding_box_nms_tb.sv
// Testbench for the bounding-box NMS block: directed sets, overflow, thresholds, random sets and backpressure.
`timescale 1ns / 1ps

module bounding_box_nms_tb;
  import bbn_pkg::*;

  localparam int NumBoxes  = 64;
  localparam int Watchdog  = 20000;
  localparam int DrainWait = 2 * NumBoxes + 20;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  box_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  box_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bounding_box_nms i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Mirror of the block's state.
  logic [15:0] iou_thr;
  box_in_t     set_boxes[$];
  logic        set_dropped;
  box_out_t    kept_queue[$];

  int  errors;
  int  idle_cycles;
  bit  hold_output;
  int  hold_cycles;
  int  recv_wait;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [12:0] extent(logic [11:0] lo, logic [11:0] hi);
    return (hi >= lo) ? 13'(hi - lo) + 13'd1 : 13'd0;
  endfunction

  function automatic bit overlap_exceeds(box_in_t a, box_in_t b);
    logic [11:0] x0, y0, x1, y1;
    logic [63:0] inter, area_a, area_b, uni;
    x0 = (a.box_left > b.box_left) ? a.box_left : b.box_left;
    y0 = (a.box_top > b.box_top) ? a.box_top : b.box_top;
    x1 = (a.box_right < b.box_right) ? a.box_right : b.box_right;
    y1 = (a.box_bottom < b.box_bottom) ? a.box_bottom : b.box_bottom;
    inter  = 64'(extent(x0, x1)) * 64'(extent(y0, y1));
    area_a = 64'(extent(a.box_left, a.box_right)) * 64'(extent(a.box_top, a.box_bottom));
    area_b = 64'(extent(b.box_left, b.box_right)) * 64'(extent(b.box_top, b.box_bottom));
    uni    = area_a + area_b - inter;
    return (inter << 16) > 64'(iou_thr) * uni;
  endfunction

  // Adds one box to the mirrored set and, on a closing box, queues the survivors.
  task automatic predict_survivors(box_in_t b);
    bit keep[NumBoxes];
    int last_idx;
    box_out_t r;
    if (set_boxes.size() < NumBoxes) set_boxes = {set_boxes, b};
    else set_dropped = 1'b1;
    if (!b.last_box) return;
    last_idx = 0;
    foreach (set_boxes[i]) begin
      keep[i] = 1'b1;
      foreach (set_boxes[j]) begin
        if (set_boxes[j].score > set_boxes[i].score &&
            overlap_exceeds(set_boxes[i], set_boxes[j])) begin
          keep[i] = 1'b0;
          break;
        end
      end
      if (keep[i]) last_idx = i;
    end
    foreach (set_boxes[i]) begin
      if (keep[i]) begin
        r.kept_left   = set_boxes[i].box_left;
        r.kept_top    = set_boxes[i].box_top;
        r.kept_right  = set_boxes[i].box_right;
        r.kept_bottom = set_boxes[i].box_bottom;
        r.kept_score  = set_boxes[i].score;
        r.kept_class  = set_boxes[i].class_label;
        r.overflow    = set_dropped;
        r.last_kept   = (i == last_idx);
        kept_queue = {kept_queue, r};
      end
    end
    set_boxes.delete();
    set_dropped = 1'b0;
  endtask

  // Valid stays high into the next item when there is no gap; it drops only for idle cycles.
  task automatic send_box(box_in_t b, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_survivors(b);
  endtask

  function automatic box_in_t make_box(int l, int t, int r, int btm, int s, int c, bit last);
    box_in_t b;
    b.box_left = 12'(l); b.box_top = 12'(t); b.box_right = 12'(r); b.box_bottom = 12'(btm);
    b.score = 16'(s); b.class_label = 2'(c); b.last_box = last;
    return b;
  endfunction

  function automatic box_in_t random_box(int cluster_x, int cluster_y, bit last);
    box_in_t b;
    int w, h;
    w = $urandom_range(1, 400);
    h = $urandom_range(1, 400);
    b.box_left   = 12'(cluster_x + $urandom_range(0, 60));
    b.box_top    = 12'(cluster_y + $urandom_range(0, 60));
    b.box_right  = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'(b.box_left + w);
    b.box_bottom = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'(b.box_top + h);
    if (b.box_right < b.box_left && $urandom_range(0, 1)) b.box_right = 12'hfff;
    b.score       = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3) * 21845)
                                                : 16'($urandom);
    b.class_label = 2'($urandom);
    b.last_box    = last;
    return b;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (kept_queue.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegIouThreshold) << 2;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    iou_thr = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_directed();
    send_box(make_box(0, 0, 4095, 4095, 65535, 3, 1'b1));
    send_box(make_box(10, 10, 109, 109, 1000, 0, 1'b0));
    send_box(make_box(12, 12, 111, 111, 2000, 1, 1'b0));
    send_box(make_box(12, 12, 111, 111, 2000, 2, 1'b0));
    send_box(make_box(200, 50, 100, 40, 65535, 3, 1'b0));
    send_box(make_box(4095, 4095, 4095, 4095, 0, 0, 1'b0));
    send_box(make_box(4095, 4095, 4095, 4095, 1, 1, 1'b1));
    send_box(make_box(0, 0, 0, 0, 0, 0, 1'b1));
    send_box(make_box(1365, 2730, 2730, 1365, 43690, 2, 1'b0));
    send_box(make_box(2730, 1365, 3000, 2000, 21845, 1, 1'b1));
  endtask

  // More boxes than the store holds, closing box included in the drop.
  task automatic test_overflow();
    for (int i = 0; i < NumBoxes + 2; i++) begin
      send_box(random_box(0, 0, i == NumBoxes + 1), 1'b1);
    end
  endtask

  task automatic test_thresholds();
    logic [15:0] thr_list[4] = '{16'd0, 16'd65535, 16'd6553, 16'd45000};
    foreach (thr_list[k]) begin
      write_threshold(thr_list[k]);
      for (int i = 0; i < 6; i++) send_box(random_box(100, 100, i == 5));
    end
    write_threshold(ThrReset);
  endtask

  task automatic test_random_sets(int total);
    int sent, n, cx, cy;
    sent = 0;
    while (sent < total) begin
      n  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      cx = $urandom_range(0, 3600);
      cy = $urandom_range(0, 3600);
      for (int i = 0; i < n; i++) send_box(random_box(cx, cy, i == n - 1));
      if ($urandom_range(0, 7) == 0) send_box(random_box(cx, cy, 1'b1));
      sent += n;
    end
  endtask

  // The receiver holds off while sets keep coming, so the block backs up.
  task automatic test_backpressure();
    hold_cycles = 600;
    hold_output = 1'b1;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < 5; i++) send_box(random_box(500, 500, i == 4), 1'b1);
    end
    wait_drained();
  endtask

  // Each offered result waits a drawn number of cycles before it is taken.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= $urandom_range(0, 6);
    end else if (hold_output) begin
      out_stall <= 1'b1;
      if (hold_cycles == 0) hold_output <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else if (!out_valid) begin
      out_stall <= 1'b0;
    end else if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait <= recv_wait - 1;
    end else begin
      out_stall <= 1'b0;
      recv_wait <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    box_out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (kept_queue.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        exp_r = kept_queue.pop_front();
        if (out_data !== exp_r) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Watchdog) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    hold_output = 1'b0;
    hold_cycles = 0;
    iou_thr     = ThrReset;
    set_dropped = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_overflow();
    test_thresholds();
    test_backpressure();
    test_random_sets(210);
    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bbn_pkg.sv
rtl/bbn_cell.sv
rtl/bounding_box_nms.sv
bench/bounding_box_nms_tb.sv
